### design/jmh_pkg.sv
// ----------------------------------------------------------------------------
// jmh_pkg
// Shared types and constants for the job max-heap with drop-min core.
// ----------------------------------------------------------------------------
`default_nettype none
package jmh_pkg;

	localparam int CAPACITY = 1024;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// Request kinds.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_MAX      = 3'd1;
	localparam logic [2:0] ST_MIN      = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic        [1:0]  req_type;
		logic signed [31:0] job_ident;
		logic signed [31:0] job_priority;
	} req_t;

	typedef struct packed {
		logic        [2:0]    status;
		logic signed [31:0]   out_ident;
		logic signed [31:0]   out_priority;
		logic        [CW-1:0] waiting_count;
	} res_t;

	// One heap slot.
	typedef struct packed {
		logic signed [31:0] ident;
		logic signed [31:0] prio;
	} job_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_START,
		OP_INS_LOAD,
		OP_RD_PARENT,
		OP_UP_STEP,
		OP_RD_L,
		OP_TAKE_L,
		OP_TAKE_R,
		OP_DOWN_STEP,
		OP_WRITE_E,
		OP_RD_ROOT,
		OP_POP_TAKE,
		OP_RD_LAST,
		OP_LOAD_E,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_DROP_TAKE
	} dp_op_t;

	// Status flags returned by the datapath.
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic pos_zero;
		logic up_swap;
		logic l_in;
		logic best_child;
		logic scan_done;
		logic lo_lt_cnt;
	} dp_stat_t;

endpackage
`default_nettype wire

### design/job_max_heap_with_drop_min_core.sv
// ----------------------------------------------------------------------------
// job_max_heap_with_drop_min_core
// Job queue as a binary max-heap on priority with insert, pop-max, drop-min.
// ----------------------------------------------------------------------------
// Channel   Ports                 Accepted when
// request   start, busy, req      start high and busy low at a clock edge
// result    strobe, result        strobe high (one cycle, cannot be stalled)
//
// One request at a time; busy stays high until its result strobe, and the next
// item can be accepted in the cycle after the strobe. An empty or full answer
// needs only the count check. Insert climbs levels until it stops at or below
// the root. Pop-max ends once the root is taken when it empties the queue, else
// moves the last job to the root and descends levels until it stops. Drop-min
// scans all n jobs held (up to 1024), one slot per cycle through the heap
// memory read port; it ends when the last slot is dropped, else moves the last
// job into the freed slot and sifts it as above.
// Reset empties the queue at once; the heap memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module job_max_heap_with_drop_min_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire jmh_pkg::req_t req,
	output logic               strobe,
	output jmh_pkg::res_t      result
);
	import jmh_pkg::*;

	dp_op_t        op;
	dp_stat_t      stat;
	job_t          res_job;
	logic [CW-1:0] count;
	logic [2:0]    status;

	jmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.op       (op),
		.busy     (busy),
		.strobe   (strobe),
		.status   (status)
	);

	jmh_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.req     (req),
		.stat    (stat),
		.res_job (res_job),
		.count   (count)
	);

	assign result.status        = status;
	assign result.out_ident     = res_job.ident;
	assign result.out_priority  = res_job.prio;
	assign result.waiting_count = count;

	// The count never exceeds capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY)) else $error("job count above capacity");

	// A result strobe is a single cycle and returns the block to idle.
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe && !busy) else $error("strobe not followed by idle");

	// An accepted request makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request not busy");

	// A removed job is reported only with a removal status.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_EMPTY || status == ST_FULL || status == ST_INSERTED)
		|-> res_job == '0) else $error("nonzero payload without removal");

endmodule
`default_nettype wire

### design/jmh_ram.sv
// ----------------------------------------------------------------------------
// jmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module jmh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### design/jmh_dp.sv
// ----------------------------------------------------------------------------
// jmh_dp
// Heap datapath: slot memory, moving-entry register, position, count, scan.
// ----------------------------------------------------------------------------
`default_nettype none
module jmh_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire jmh_pkg::dp_op_t op,
	input  wire jmh_pkg::req_t  req,
	output jmh_pkg::dp_stat_t   stat,
	output jmh_pkg::job_t       res_job,
	output logic [jmh_pkg::CW-1:0] count
);
	import jmh_pkg::*;

	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   pos_q;
	job_t            e_q;
	job_t            best_q;
	logic [AW-1:0]   best_idx_q;
	logic            best_child_q;
	job_t            res_q;
	job_t            min_q;
	logic [AW-1:0]   lo_q;
	logic [CW-1:0]   scan_idx_q;
	logic            scan_v_s1;
	logic [AW-1:0]   scan_idx_s1;

	logic            we;
	logic [AW-1:0]   waddr;
	job_t            wdata;
	logic [AW-1:0]   raddr;
	logic [63:0]     rdata_raw;
	job_t            rdata;
	logic [AW-1:0]   parent;
	logic [AW+1:0]   lft;
	logic [AW+1:0]   rgt;
	logic            r_in;

	assign rdata  = job_t'(rdata_raw);
	assign parent = AW'((pos_q - AW'(1)) >> 1);
	assign lft    = {1'b0, pos_q, 1'b1};
	assign rgt    = lft + (AW+2)'(1);
	assign r_in   = rgt < (AW+2)'(cnt_q);

	jmh_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	// Memory port selection per operation.
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = e_q;
		raddr = '0;
		unique case (op)
			OP_RD_PARENT: raddr = parent;
			OP_UP_STEP: begin
				we    = 1'b1;
				wdata = rdata;
			end
			OP_RD_L:      raddr = lft[AW-1:0];
			OP_TAKE_L:    raddr = rgt[AW-1:0];
			OP_DOWN_STEP: begin
				we    = 1'b1;
				wdata = best_q;
			end
			OP_WRITE_E:   we = 1'b1;
			OP_RD_LAST:   raddr = cnt_q[AW-1:0];
			OP_SCAN_STEP: raddr = scan_idx_q[AW-1:0];
			default: ;
		endcase
	end

	// Status back to the controller.
	always_comb begin
		stat.cnt_zero   = cnt_q == '0;
		stat.cnt_full   = cnt_q == CW'(CAPACITY);
		stat.pos_zero   = pos_q == '0;
		stat.up_swap    = rdata.prio < e_q.prio;
		stat.l_in       = lft < (AW+2)'(cnt_q);
		stat.best_child = best_child_q;
		stat.scan_done  = (scan_idx_q >= cnt_q) && !scan_v_s1;
		stat.lo_lt_cnt  = CW'(lo_q) < cnt_q;
	end

	// Count register and scan valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			if (op == OP_INS_LOAD) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (op == OP_POP_TAKE || op == OP_DROP_TAKE) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (op == OP_SCAN_STEP) begin
				scan_v_s1 <= scan_idx_q < cnt_q;
			end else begin
				scan_v_s1 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_START: begin
				e_q.ident <= req.job_ident;
				e_q.prio  <= req.job_priority;
				res_q     <= '0;
			end
			OP_INS_LOAD: pos_q <= cnt_q[AW-1:0];
			OP_UP_STEP:  pos_q <= parent;
			OP_TAKE_L: begin
				if (e_q.prio < rdata.prio) begin
					best_q       <= rdata;
					best_idx_q   <= lft[AW-1:0];
					best_child_q <= 1'b1;
				end else begin
					best_q       <= e_q;
					best_child_q <= 1'b0;
				end
			end
			OP_TAKE_R: begin
				if (r_in && (best_q.prio < rdata.prio)) begin
					best_q       <= rdata;
					best_idx_q   <= rgt[AW-1:0];
					best_child_q <= 1'b1;
				end
			end
			OP_DOWN_STEP: pos_q <= best_idx_q;
			OP_POP_TAKE: begin
				res_q <= rdata;
				pos_q <= '0;
			end
			OP_LOAD_E: e_q <= rdata;
			OP_SCAN_START: scan_idx_q <= '0;
			OP_SCAN_STEP: begin
				if (scan_idx_q < cnt_q) begin
					scan_idx_q  <= scan_idx_q + CW'(1);
					scan_idx_s1 <= scan_idx_q[AW-1:0];
				end
				// Keep the first index holding the lowest priority.
				if (scan_v_s1 && (scan_idx_s1 == '0 || rdata.prio < min_q.prio)) begin
					min_q <= rdata;
					lo_q  <= scan_idx_s1;
				end
			end
			OP_DROP_TAKE: begin
				res_q <= min_q;
				pos_q <= lo_q;
			end
			default: ;
		endcase
	end

	assign res_job = res_q;
	assign count   = cnt_q;

endmodule
`default_nettype wire

### design/jmh_ctrl.sv
// ----------------------------------------------------------------------------
// jmh_ctrl
// Request sequencer: walks insert, pop-max and drop-min through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module jmh_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       req_type,
	input  wire jmh_pkg::dp_stat_t stat,
	output jmh_pkg::dp_op_t       op,
	output logic                  busy,
	output logic                  strobe,
	output logic [2:0]            status
);
	import jmh_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHK, S_INS, S_UP_CHK, S_UP_RD, S_UP_CMP, S_DN_CHK, S_DN_L,
		S_DN_R, S_DN_MV, S_WR, S_POP_RD, S_POP_TK, S_POP_CHK, S_LAST_RD,
		S_LAST_LD, S_SCAN_ST, S_SCAN, S_DR_TK, S_DR_CHK, S_DONE
	} state_t;

	typedef enum logic [1:0] {K_INS, K_POP, K_DROP} kind_t;

	state_t state_q;
	kind_t  kind_q;
	logic [2:0] st_q;

	// Operation issued in each state.
	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_IDLE:    if (start) op = OP_START;
			S_INS:     op = OP_INS_LOAD;
			S_UP_RD:   op = OP_RD_PARENT;
			S_UP_CMP:  if (stat.up_swap) op = OP_UP_STEP;
			S_DN_CHK:  if (stat.l_in) op = OP_RD_L;
			S_DN_L:    op = OP_TAKE_L;
			S_DN_R:    op = OP_TAKE_R;
			S_DN_MV:   if (stat.best_child) op = OP_DOWN_STEP;
			S_WR:      op = OP_WRITE_E;
			S_POP_RD:  op = OP_RD_ROOT;
			S_POP_TK:  op = OP_POP_TAKE;
			S_LAST_RD: op = OP_RD_LAST;
			S_LAST_LD: op = OP_LOAD_E;
			S_SCAN_ST: op = OP_SCAN_START;
			S_SCAN:    op = OP_SCAN_STEP;
			S_DR_TK:   op = OP_DROP_TAKE;
			default: ;
		endcase
	end

	// State and result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_INS;
			st_q    <= ST_INSERTED;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_CHK;
					if (req_type == REQ_INSERT)   kind_q <= K_INS;
					else if (req_type == REQ_POP) kind_q <= K_POP;
					else                          kind_q <= K_DROP;
				end
				S_CHK: begin
					if (kind_q == K_INS) begin
						if (stat.cnt_full) begin
							st_q    <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							st_q    <= ST_INSERTED;
							state_q <= S_INS;
						end
					end else if (stat.cnt_zero) begin
						st_q    <= ST_EMPTY;
						state_q <= S_DONE;
					end else if (kind_q == K_POP) begin
						st_q    <= ST_MAX;
						state_q <= S_POP_RD;
					end else begin
						st_q    <= ST_MIN;
						state_q <= S_SCAN_ST;
					end
				end
				S_INS: state_q <= S_UP_CHK;
				S_UP_CHK: begin
					if (!stat.pos_zero)        state_q <= S_UP_RD;
					else if (kind_q == K_INS)  state_q <= S_WR;
					else                       state_q <= S_DN_CHK;
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (stat.up_swap)          state_q <= S_UP_CHK;
					else if (kind_q == K_INS)  state_q <= S_WR;
					else                       state_q <= S_DN_CHK;
				end
				S_DN_CHK:  state_q <= stat.l_in ? S_DN_L : S_WR;
				S_DN_L:    state_q <= S_DN_R;
				S_DN_R:    state_q <= S_DN_MV;
				S_DN_MV:   state_q <= stat.best_child ? S_DN_CHK : S_WR;
				S_WR:      state_q <= S_DONE;
				S_POP_RD:  state_q <= S_POP_TK;
				S_POP_TK:  state_q <= S_POP_CHK;
				S_POP_CHK: state_q <= stat.cnt_zero ? S_DONE : S_LAST_RD;
				S_LAST_RD: state_q <= S_LAST_LD;
				S_LAST_LD: state_q <= (kind_q == K_POP) ? S_DN_CHK : S_UP_CHK;
				S_SCAN_ST: state_q <= S_SCAN;
				S_SCAN:    if (stat.scan_done) state_q <= S_DR_TK;
				S_DR_TK:   state_q <= S_DR_CHK;
				S_DR_CHK:  state_q <= stat.lo_lt_cnt ? S_LAST_RD : S_DONE;
				S_DONE:    state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = state_q == S_DONE;
	assign status = st_q;

endmodule
`default_nettype wire
